### hw/rtl/calu_pkg.sv
// calu_pkg: shared types and constants for the 8/16-bit alu with kept flags
// depends on nothing; used by calu_core, cpu_alu_with_flags and calu_checker
package calu_pkg;

  localparam int OP_W   = 5;
  localparam int DATA_W = 16;
  localparam int BYTE_W = 8;

  // operation codes as carried on in_op
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_SWAP  = 5'd10,
    OP_CPL   = 5'd11,
    OP_CCF   = 5'd12,
    OP_SCF   = 5'd13,
    OP_RLC   = 5'd14,
    OP_RL    = 5'd15,
    OP_RRC   = 5'd16,
    OP_RR    = 5'd17,
    OP_SLA   = 5'd18,
    OP_SRA   = 5'd19,
    OP_SRL   = 5'd20,
    OP_RLCA  = 5'd21,
    OP_RLA   = 5'd22,
    OP_RRCA  = 5'd23,
    OP_RRA   = 5'd24,
    OP_ADD16 = 5'd25,
    OP_ADDSP = 5'd26,
    OP_INC16 = 5'd27,
    OP_DEC16 = 5'd28
  } op_t;

  // kept flag register, z in the top bit
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

### hw/rtl/cpu_alu_with_flags.sv
// cpu_alu_with_flags: top level, input register, alu datapath and result/flag register
// depends on calu_pkg and calu_core
//
// An 8-bit cpu alu with a kept z/n/h/c flag register and a few 16-bit adds.
// Each request on the in_ channel carries an operation code and two operands;
// each one gives exactly one request on the out_ channel with the result and
// the new flags, in order. The block takes one request per cycle, sustained
// while the output is drained: a request is captured in the input register,
// passes the single-pass alu datapath and lands in the output register, which
// drives out_valid and the result; a full output register held by a low
// out_ready keeps the request waiting in the input register.
// The flag register is the output register's flag field itself; it is written
// at the same edge as each result and fed straight back into the datapath, so
// the request behind picks up the flags of the one ahead with no gap. While a
// result waits on out_ready the input register still takes one more request;
// in_ready drops only when both stages are full. Reset clears the flags.
module cpu_alu_with_flags (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [calu_pkg::OP_W-1:0]     in_op,
  input  logic [calu_pkg::DATA_W-1:0]   in_operand_a,
  input  logic [calu_pkg::DATA_W-1:0]   in_operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [calu_pkg::DATA_W-1:0]   out_result,
  output logic                          out_zero_flag,
  output logic                          out_subtract_flag,
  output logic                          out_half_carry_flag,
  output logic                          out_carry_flag
);
  import calu_pkg::*;

  // input register stage
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [DATA_W-1:0] s1_a_r;
  logic [DATA_W-1:0] s1_b_r;

  // output register stage; flags_r is also the kept flag state
  logic              out_valid_r;
  logic [DATA_W-1:0] out_result_r;
  flags_t            flags_r;

  logic              in_take;
  logic              s1_move;
  logic [DATA_W-1:0] alu_result;
  flags_t            flags_nxt;

  // stage one moves on when the output register is empty or being drained
  assign s1_move  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_move;
  assign in_take  = in_valid & in_ready;

  calu_core u_core (
    .op        (op_t'(s1_op_r)),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .flags_in  (flags_r),
    .result    (alu_result),
    .flags_out (flags_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= in_op;
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
    end
    if (s1_move) begin
      out_result_r <= alu_result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result          = out_result_r;
  assign out_zero_flag       = flags_r.z;
  assign out_subtract_flag   = flags_r.n;
  assign out_half_carry_flag = flags_r.h;
  assign out_carry_flag      = flags_r.c;

endmodule

### hw/rtl/calu_core.sv
// calu_core: combinational datapath, one operation on two operands plus the kept flags
// depends on calu_pkg
module calu_core (
  input  calu_pkg::op_t                   op,
  input  logic [calu_pkg::DATA_W-1:0]     operand_a,
  input  logic [calu_pkg::DATA_W-1:0]     operand_b,
  input  calu_pkg::flags_t                flags_in,
  output logic [calu_pkg::DATA_W-1:0]     result,
  output calu_pkg::flags_t                flags_out
);
  import calu_pkg::*;

  logic [BYTE_W-1:0] a8;
  logic [BYTE_W-1:0] b8;
  logic              add_ci;
  logic              sub_ci;
  logic [BYTE_W:0]   add9;
  logic [4:0]        add_lo;
  logic [BYTE_W:0]   sub9;
  logic [4:0]        sub_lo;
  logic [BYTE_W-1:0] inc8;
  logic [BYTE_W-1:0] dec8;
  logic [DATA_W:0]   add17;
  logic [12:0]       add_lo12;
  logic [DATA_W-1:0] sp16;
  logic [4:0]        sp_lo;
  logic [BYTE_W:0]   sp9;
  logic [BYTE_W-1:0] rot8;
  logic              rot_c;

  assign a8 = operand_a[BYTE_W-1:0];
  assign b8 = operand_b[BYTE_W-1:0];

  assign add_ci = (op == OP_ADC) & flags_in.c;
  assign sub_ci = (op == OP_SBC) & flags_in.c;

  assign add9   = {1'b0, a8} + {1'b0, b8} + {{BYTE_W{1'b0}}, add_ci};
  assign add_lo = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, add_ci};
  // borrow shows as the top bit of the widened difference
  assign sub9   = {1'b0, a8} - {1'b0, b8} - {{BYTE_W{1'b0}}, sub_ci};
  assign sub_lo = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'b0, sub_ci};

  assign inc8 = a8 + 8'd1;
  assign dec8 = a8 - 8'd1;

  assign add17    = {1'b0, operand_a} + {1'b0, operand_b};
  assign add_lo12 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

  // signed byte offset; flags from the unsigned low-byte add
  assign sp16  = operand_a + {{(DATA_W-BYTE_W){b8[BYTE_W-1]}}, b8};
  assign sp_lo = {1'b0, operand_a[3:0]} + {1'b0, b8[3:0]};
  assign sp9   = {1'b0, operand_a[BYTE_W-1:0]} + {1'b0, b8};

  // shared rotate / shift unit for cb-prefixed and accumulator forms
  always_comb begin
    rot8  = a8;
    rot_c = 1'b0;
    unique case (op)
      OP_RLC, OP_RLCA: begin
        rot8  = {a8[6:0], a8[7]};
        rot_c = a8[7];
      end
      OP_RL, OP_RLA: begin
        rot8  = {a8[6:0], flags_in.c};
        rot_c = a8[7];
      end
      OP_RRC, OP_RRCA: begin
        rot8  = {a8[0], a8[7:1]};
        rot_c = a8[0];
      end
      OP_RR, OP_RRA: begin
        rot8  = {flags_in.c, a8[7:1]};
        rot_c = a8[0];
      end
      OP_SLA: begin
        rot8  = {a8[6:0], 1'b0};
        rot_c = a8[7];
      end
      OP_SRA: begin
        rot8  = {a8[7], a8[7:1]};
        rot_c = a8[0];
      end
      OP_SRL: begin
        rot8  = {1'b0, a8[7:1]};
        rot_c = a8[0];
      end
      default: begin
        rot8  = a8;
        rot_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    result    = operand_a;
    flags_out = flags_in;
    unique case (op)
      OP_ADD, OP_ADC: begin
        result    = {8'h00, add9[BYTE_W-1:0]};
        flags_out = '{z: (add9[BYTE_W-1:0] == '0), n: 1'b0, h: add_lo[4], c: add9[BYTE_W]};
      end
      OP_SUB, OP_SBC: begin
        result    = {8'h00, sub9[BYTE_W-1:0]};
        flags_out = '{z: (sub9[BYTE_W-1:0] == '0), n: 1'b1, h: sub_lo[4], c: sub9[BYTE_W]};
      end
      OP_CP: begin
        result    = {8'h00, a8};
        flags_out = '{z: (sub9[BYTE_W-1:0] == '0), n: 1'b1, h: sub_lo[4], c: sub9[BYTE_W]};
      end
      OP_AND: begin
        result    = {8'h00, a8 & b8};
        flags_out = '{z: ((a8 & b8) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_OR: begin
        result    = {8'h00, a8 | b8};
        flags_out = '{z: ((a8 | b8) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_XOR: begin
        result    = {8'h00, a8 ^ b8};
        flags_out = '{z: ((a8 ^ b8) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        result    = {8'h00, inc8};
        flags_out = '{z: (inc8 == '0), n: 1'b0, h: (a8[3:0] == 4'hF), c: flags_in.c};
      end
      OP_DEC: begin
        result    = {8'h00, dec8};
        flags_out = '{z: (dec8 == '0), n: 1'b1, h: (a8[3:0] == 4'h0), c: flags_in.c};
      end
      OP_SWAP: begin
        result    = {8'h00, a8[3:0], a8[7:4]};
        flags_out = '{z: (a8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_CPL: begin
        result    = {8'h00, ~a8};
        flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
      end
      OP_CCF: begin
        result    = {8'h00, a8};
        flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
      end
      OP_SCF: begin
        result    = {8'h00, a8};
        flags_out = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        result    = {8'h00, rot8};
        flags_out = '{z: (rot8 == '0), n: 1'b0, h: 1'b0, c: rot_c};
      end
      OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
        // accumulator forms always clear z
        result    = {8'h00, rot8};
        flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_c};
      end
      OP_ADD16: begin
        result    = add17[DATA_W-1:0];
        flags_out = '{z: flags_in.z, n: 1'b0, h: add_lo12[12], c: add17[DATA_W]};
      end
      OP_ADDSP: begin
        result    = sp16;
        flags_out = '{z: 1'b0, n: 1'b0, h: sp_lo[4], c: sp9[BYTE_W]};
      end
      OP_INC16: begin
        result    = operand_a + 16'd1;
      end
      OP_DEC16: begin
        result    = operand_a - 16'd1;
      end
      default: begin
        // unused codes pass operand_a, flags held
        result    = operand_a;
        flags_out = flags_in;
      end
    endcase
  end

endmodule

### hw/rtl/calu_checker.sv
// calu_assertions: port-level checks on the alu top level, with its bind
// depends on calu_pkg and cpu_alu_with_flags
module calu_assertions (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [calu_pkg::OP_W-1:0]     in_op,
  input logic [calu_pkg::DATA_W-1:0]   in_operand_a,
  input logic [calu_pkg::DATA_W-1:0]   in_operand_b,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [calu_pkg::DATA_W-1:0]   out_result,
  input logic                          out_zero_flag,
  input logic                          out_subtract_flag,
  input logic                          out_half_carry_flag,
  input logic                          out_carry_flag
);
  import calu_pkg::*;

  // reset empties the result stage
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input stalls only when the output side is full and held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without back-pressure");

  // an accepted request is followed by a result on show
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("accepted request produced no result");

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result)
      && $stable(out_zero_flag) && $stable(out_subtract_flag)
      && $stable(out_half_carry_flag) && $stable(out_carry_flag)))
    else $error("stalled result changed");

  // a waiting request stays offered with its payload unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_op)
      && $stable(in_operand_a) && $stable(in_operand_b)))
    else $error("waiting request dropped or changed");

endmodule

bind cpu_alu_with_flags calu_assertions u_calu_assertions (.*);

### tb/calu_checker.sv
// calu_checker: watches the request and result channels of cpu_alu_with_flags,
// predicts each result with its own alu and kept flags and compares field by field
// depends on calu_pkg
module calu_checker
  import calu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_result,
  input  logic              out_zero_flag,
  input  logic              out_subtract_flag,
  input  logic              out_half_carry_flag,
  input  logic              out_carry_flag,
  output int                error_count,
  output int                pending_count
);

  typedef struct packed {
    logic [DATA_W-1:0] result;
    flags_t            flags;
  } alu_out_t;

  alu_out_t pending_results[$];
  flags_t   model_flags = '0;
  int       errs = 0;

  function automatic alu_out_t alu_eval(logic [OP_W-1:0] op, logic [DATA_W-1:0] a,
                                        logic [DATA_W-1:0] b, flags_t kept);
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [7:0]  r8;
    logic        ci;
    logic        outc;
    logic [8:0]  t9;
    logic [4:0]  t5;
    logic [12:0] t13;
    logic [16:0] t17;
    alu_out_t    res;
    a8         = a[7:0];
    b8         = b[7:0];
    r8         = 8'h00;
    outc       = 1'b0;
    res.result = a;
    res.flags  = kept;
    case (op)
      OP_ADD, OP_ADC: begin
        ci = (op == OP_ADC) ? kept.c : 1'b0;
        t9 = {1'b0, a8} + {1'b0, b8} + {8'h00, ci};
        t5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, ci};
        res.result = {8'h00, t9[7:0]};
        res.flags  = {t9[7:0] == 8'h00, 1'b0, t5[4], t9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // sbc half carry takes the carry in too
        ci = (op == OP_SBC) ? kept.c : 1'b0;
        t9 = {1'b0, a8} - {1'b0, b8} - {8'h00, ci};
        res.flags = {t9[7:0] == 8'h00, 1'b1,
                     {1'b0, a8[3:0]} < ({1'b0, b8[3:0]} + {4'h0, ci}),
                     {1'b0, a8} < ({1'b0, b8} + {8'h00, ci})};
        res.result = (op == OP_CP) ? {8'h00, a8} : {8'h00, t9[7:0]};
      end
      OP_AND: begin
        r8 = a8 & b8;
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_OR, OP_XOR: begin
        r8 = (op == OP_OR) ? (a8 | b8) : (a8 ^ b8);
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_INC: begin
        r8 = a8 + 8'h01;
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b0, a8[3:0] == 4'hF, kept.c};
      end
      OP_DEC: begin
        r8 = a8 - 8'h01;
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b1, a8[3:0] == 4'h0, kept.c};
      end
      OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_CPL: begin
        res.result = {8'h00, ~a8};
        res.flags  = {kept.z, 1'b1, 1'b1, kept.c};
      end
      OP_CCF, OP_SCF: begin
        res.result = {8'h00, a8};
        res.flags  = {kept.z, 1'b0, 1'b0, (op == OP_SCF) ? 1'b1 : ~kept.c};
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL,
      OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
        case (op)
          OP_RLC, OP_RLCA: begin r8 = {a8[6:0], a8[7]};   outc = a8[7]; end
          OP_RL, OP_RLA:   begin r8 = {a8[6:0], kept.c};  outc = a8[7]; end
          OP_RRC, OP_RRCA: begin r8 = {a8[0], a8[7:1]};   outc = a8[0]; end
          OP_RR, OP_RRA:   begin r8 = {kept.c, a8[7:1]};  outc = a8[0]; end
          OP_SLA:          begin r8 = {a8[6:0], 1'b0};    outc = a8[7]; end
          OP_SRA:          begin r8 = {a8[7], a8[7:1]};   outc = a8[0]; end
          default:         begin r8 = {1'b0, a8[7:1]};    outc = a8[0]; end
        endcase
        res.result = {8'h00, r8};
        // accumulator forms always clear z
        res.flags  = {(op <= OP_SRL) && (r8 == 8'h00), 1'b0, 1'b0, outc};
      end
      OP_ADD16: begin
        t17 = {1'b0, a} + {1'b0, b};
        t13 = {1'b0, a[11:0]} + {1'b0, b[11:0]};
        res.result = t17[15:0];
        res.flags  = {kept.z, 1'b0, t13[12], t17[16]};
      end
      OP_ADDSP: begin
        t5 = {1'b0, a[3:0]} + {1'b0, b8[3:0]};
        t9 = {1'b0, a[7:0]} + {1'b0, b8};
        res.result = a + {{8{b8[7]}}, b8};
        res.flags  = {1'b0, 1'b0, t5[4], t9[8]};
      end
      OP_INC16: res.result = a + 16'h0001;
      OP_DEC16: res.result = a - 16'h0001;
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      errs++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    alu_out_t want;
    if (!rst_n) begin
      model_flags = '0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = alu_eval(in_op, in_operand_a, in_operand_b, model_flags);
        model_flags = want.flags;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errs++;
          $error("result %h arrived with no request waiting", out_result);
        end else begin
          want = pending_results.pop_front();
          check_field("result", want.result, out_result);
          check_field("zero_flag", 16'(want.flags.z), 16'(out_zero_flag));
          check_field("subtract_flag", 16'(want.flags.n), 16'(out_subtract_flag));
          check_field("half_carry_flag", 16'(want.flags.h), 16'(out_half_carry_flag));
          check_field("carry_flag", 16'(want.flags.c), 16'(out_carry_flag));
        end
      end
    end
    error_count   <= errs;
    pending_count <= pending_results.size();
  end

endmodule

### tb/tb_cpu_alu_with_flags.sv
// tb_cpu_alu_with_flags: top of the alu testbench, makes the requests and the
// output back-pressure and gives the verdict; depends on calu_pkg, calu_checker
// and the cpu_alu_with_flags rtl
module tb_cpu_alu_with_flags;
  import calu_pkg::*;

  // far above the slowest correct run, hold-off included
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_REQS   = 160;
  localparam int SQUEEZE_REQS = 40;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic [OP_W-1:0]   in_op        = '0;
  logic [DATA_W-1:0] in_operand_a = '0;
  logic [DATA_W-1:0] in_operand_b = '0;
  logic              out_ready    = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [DATA_W-1:0] out_result;
  logic              out_zero_flag;
  logic              out_subtract_flag;
  logic              out_half_carry_flag;
  logic              out_carry_flag;

  int error_count;
  int pending_count;

  // knobs shared between the request process and the receiver
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int sent      = 0;
  int cycles    = 0;

  cpu_alu_with_flags DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_operand_a        (in_operand_a),
    .in_operand_b        (in_operand_b),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result          (out_result),
    .out_zero_flag       (out_zero_flag),
    .out_subtract_flag   (out_subtract_flag),
    .out_half_carry_flag (out_half_carry_flag),
    .out_carry_flag      (out_carry_flag)
  );

  calu_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_operand_a        (in_operand_a),
    .in_operand_b        (in_operand_b),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result          (out_result),
    .out_zero_flag       (out_zero_flag),
    .out_subtract_flag   (out_subtract_flag),
    .out_half_carry_flag (out_half_carry_flag),
    .out_carry_flag      (out_carry_flag),
    .error_count         (error_count),
    .pending_count       (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off counted here once asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // one request: optional idle cycles first, then valid held until the block takes it
  // in_ready read right after the edge is its value at that edge
  task automatic send_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                          input logic [DATA_W-1:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // operand mix: extremes, nibble and sign boundaries, otherwise anything
  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 4'($urandom), 4'hF};
      3:       return {8'($urandom), 8'h80};
      4:       return {8'h00, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic rand_req();
    logic [OP_W-1:0] op;
    // mostly real operations, now and then an unused code
    if ($urandom_range(0, 19) == 0) op = 5'($urandom_range(0, 31));
    else                            op = 5'($urandom_range(0, OP_DEC16));
    send_req(op, pick_operand(), pick_operand());
  endtask

  task automatic run_phase(input int reqs, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (reqs) rand_req();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every code once, unused ones too, with operands at the extremes
    for (int k = 0; k < 32; k++) begin
      send_req(5'(k), k[0] ? 16'hFFFF : 16'h0000, k[1] ? 16'hFFFF : 16'h0080);
    end
    // adc with carry in forming the half carry
    send_req(OP_SCF, 16'h000F, 16'h0000);
    send_req(OP_ADC, 16'h000F, 16'h0000);
    // sbc with the carry in set: a half borrow and a zero result
    send_req(OP_SCF, 16'h0010, 16'h0000);
    send_req(OP_SBC, 16'h0010, 16'h000F);
    // sra keeps the sign bit
    send_req(OP_SRA, 16'h0081, 16'h0000);
    // rlc feeds bit 7 back, not the old carry
    send_req(OP_RLC, 16'h0080, 16'h0000);
    // inc wrapping to zero keeps the carry set by scf
    send_req(OP_SCF, 16'h0000, 16'h0000);
    send_req(OP_INC, 16'h00FF, 16'h0000);
    // compare on equal operands returns operand a
    send_req(OP_CP, 16'h0042, 16'h0042);
    // accumulator rotate on zero still clears z
    send_req(OP_RLCA, 16'h0000, 16'h0000);
    // 16-bit carries out of bits 11 and 15
    send_req(OP_ADD16, 16'h0FFF, 16'h0001);
    send_req(OP_ADD16, 16'hFFFF, 16'h0001);
    // sp add with a negative offset
    send_req(OP_ADDSP, 16'h0000, 16'h00FF);
    send_req(OP_ADDSP, 16'h00FF, 16'hFF01);

    run_phase(PHASE_REQS, 0, 0);
    run_phase(PHASE_REQS, 60, 0);
    run_phase(PHASE_REQS, 0, 60);
    run_phase(PHASE_REQS, 8, 8);

    // back-pressure: output held off while requests keep coming, both stages fill
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (SQUEEZE_REQS) rand_req();

    in_valid <= 1'b0;
    // let the checker's count catch up with the last request
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d requests: all operation codes, operand extremes,", sent);
    $display("idle and stall mixes and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
